// ===== rtl/core/fjsb_pkg.sv =====
// Shared field widths for the schedule builder.
`timescale 1ns / 1ps
`default_nettype none
package fjsb_pkg;
   localparam int unsigned JOB_ID_W  = 6;
   localparam int unsigned MACH_ID_W = 5;
   localparam int unsigned DUR_W     = 16;
   localparam int unsigned OUT_W     = 32;
   localparam int unsigned JOB_IDS   = 1 << JOB_ID_W;
   localparam int unsigned MACH_IDS  = 1 << MACH_ID_W;
endpackage
`default_nettype wire

// ===== rtl/core/fjsb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fjsb_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/core/flexible_job_shop_schedule_builder_unit.sv =====
// Top level of the flexible job shop schedule builder.
//
//   channel | direction | words
//   req_    | in        | one operation: job, machine, duration, flags
//   rsp_    | out       | one result per operation: times and objectives
//
// One operation per cycle sustained unless rsp_ stalls; a result is registered in stage A,
// stage B and the output register. The rate is set by the read-modify-write of the job
// and machine memories, one entry of each per cycle, with the last write forwarded to the
// next read. Reset clears the entry valid bits and objectives; no memory sweep.
// A stalled result backs up through two internal stages before req_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module flexible_job_shop_schedule_builder_unit #(
   parameter int unsigned MAX_JOBS     = 64,
   parameter int unsigned MAX_MACHINES = 32,
   parameter int unsigned TIME_BITS    = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [fjsb_pkg::JOB_ID_W-1:0]   req_job_id,
   input  logic [fjsb_pkg::MACH_ID_W-1:0]  req_machine_id,
   input  logic [fjsb_pkg::DUR_W-1:0]      req_duration,
   input  logic                            req_job_finished,
   input  logic                            req_new_schedule,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [fjsb_pkg::OUT_W-1:0]      rsp_start_time,
   output logic [fjsb_pkg::OUT_W-1:0]      rsp_end_time,
   output logic [fjsb_pkg::OUT_W-1:0]      rsp_makespan,
   output logic [fjsb_pkg::OUT_W-1:0]      rsp_total_completion,
   output logic [fjsb_pkg::OUT_W-1:0]      rsp_max_workload,
   output logic [fjsb_pkg::OUT_W-1:0]      rsp_total_workload
);
   import fjsb_pkg::*;

   localparam int unsigned TW = TIME_BITS;
   // ids above the field range never arrive, so storage stops there
   localparam int unsigned JOB_DEPTH  = (MAX_JOBS < JOB_IDS) ? MAX_JOBS : JOB_IDS;
   localparam int unsigned MACH_DEPTH = (MAX_MACHINES < MACH_IDS) ? MAX_MACHINES : MACH_IDS;
   localparam int unsigned JAW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
   localparam int unsigned MAW = (MACH_DEPTH > 1) ? $clog2(MACH_DEPTH) : 1;

   function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
      logic [TW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TW] ? {TW{1'b1}} : s[TW-1:0];
   endfunction

   // id folding tables, worked out at elaboration
   logic [JAW-1:0] job_map  [JOB_IDS];
   logic [MAW-1:0] mach_map [MACH_IDS];

   for (genvar gi = 0; gi < JOB_IDS; gi++) begin : g_job_map
      localparam int unsigned JV = gi % JOB_DEPTH;
      assign job_map[gi] = JAW'(JV);
   end
   for (genvar gm = 0; gm < MACH_IDS; gm++) begin : g_mach_map
      localparam int unsigned MV = gm % MACH_DEPTH;
      assign mach_map[gm] = MAW'(MV);
   end

   // handshake
   logic out_free, b_free, a_free, accept, a_move, b_move;
   logic a_valid_ff, a_valid_in, b_valid_ff, b_valid_in, rsp_valid_ff, rsp_valid_in;

   // stage A: memory data arrives, read-modify-write
   logic [JAW-1:0]   a_job_ff;
   logic [MAW-1:0]   a_mach_ff;
   logic [DUR_W-1:0] a_dur_ff;
   logic             a_fin_ff, a_fresh_ff;

   logic [TW-1:0]    job_rd_data;
   logic [2*TW-1:0]  mach_rd_data;
   logic [TW-1:0]    a_jr, a_mr, a_ml, a_start, a_end, a_load;

   // forward of the last write to each memory
   logic [JAW-1:0]   fj_idx_ff;
   logic [TW-1:0]    fj_data_ff;
   logic [MAW-1:0]   fm_idx_ff;
   logic [2*TW-1:0]  fm_data_ff;
   logic [2*TW-1:0]  a_mach_word;

   logic [JOB_DEPTH-1:0]  job_valid_ff, job_valid_in;
   logic [MACH_DEPTH-1:0] mach_valid_ff, mach_valid_in;

   // stage B: objectives
   logic [TW-1:0]    b_start_ff, b_end_ff, b_load_ff;
   logic [DUR_W-1:0] b_dur_ff;
   logic             b_fin_ff, b_fresh_ff;

   logic [TW-1:0]    o_start_ff, o_end_ff;
   logic [TW-1:0]    makespan_ff, makespan_in, completion_ff, completion_in;
   logic [TW-1:0]    max_load_ff, max_load_in, total_load_ff, total_load_in;
   logic [TW-1:0]    base_ms, base_cs, base_ml, base_tl;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign b_free   = !b_valid_ff || out_free;
   assign a_free   = !a_valid_ff || b_free;
   assign accept   = req_valid && a_free;
   assign a_move   = a_valid_ff && b_free;
   assign b_move   = b_valid_ff && out_free;
   assign req_ready = a_free;

   assign a_valid_in   = a_free ? req_valid : a_valid_ff;
   assign b_valid_in   = b_free ? a_valid_ff : b_valid_ff;
   assign rsp_valid_in = out_free ? b_valid_ff : rsp_valid_ff;

   fjsb_ram #(.WIDTH(TW), .DEPTH(JOB_DEPTH)) u_job_ram (
      .clock   (clock),
      .wr_en   (a_move),
      .wr_addr (a_job_ff),
      .wr_data (a_end),
      .rd_en   (accept),
      .rd_addr (job_map[req_job_id]),
      .rd_data (job_rd_data)
   );

   // machine word: load in the upper half, ready time in the lower
   fjsb_ram #(.WIDTH(2*TW), .DEPTH(MACH_DEPTH)) u_mach_ram (
      .clock   (clock),
      .wr_en   (a_move),
      .wr_addr (a_mach_ff),
      .wr_data ({a_load, a_end}),
      .rd_en   (accept),
      .rd_addr (mach_map[req_machine_id]),
      .rd_data (mach_rd_data)
   );

   always_comb begin
      a_jr = '0;
      if (!a_fresh_ff && job_valid_ff[a_job_ff]) begin
         a_jr = (fj_idx_ff == a_job_ff) ? fj_data_ff : job_rd_data;
      end
      a_mach_word = '0;
      if (!a_fresh_ff && mach_valid_ff[a_mach_ff]) begin
         a_mach_word = (fm_idx_ff == a_mach_ff) ? fm_data_ff : mach_rd_data;
      end
      a_mr    = a_mach_word[TW-1:0];
      a_ml    = a_mach_word[2*TW-1:TW];
      a_start = (a_jr > a_mr) ? a_jr : a_mr;
      a_end   = sat_add(a_start, TW'(a_dur_ff));
      a_load  = sat_add(a_ml, TW'(a_dur_ff));
   end

   always_comb begin
      job_valid_in  = job_valid_ff;
      mach_valid_in = mach_valid_ff;
      if (a_move) begin
         job_valid_in  = (a_fresh_ff ? '0 : job_valid_ff) | (JOB_DEPTH'(1) << a_job_ff);
         mach_valid_in = (a_fresh_ff ? '0 : mach_valid_ff) | (MACH_DEPTH'(1) << a_mach_ff);
      end
   end

   always_comb begin
      base_ms = b_fresh_ff ? '0 : makespan_ff;
      base_cs = b_fresh_ff ? '0 : completion_ff;
      base_ml = b_fresh_ff ? '0 : max_load_ff;
      base_tl = b_fresh_ff ? '0 : total_load_ff;
      makespan_in   = makespan_ff;
      completion_in = completion_ff;
      max_load_in   = max_load_ff;
      total_load_in = total_load_ff;
      if (b_move) begin
         makespan_in   = (b_end_ff > base_ms) ? b_end_ff : base_ms;
         completion_in = b_fin_ff ? sat_add(base_cs, b_end_ff) : base_cs;
         max_load_in   = (b_load_ff > base_ml) ? b_load_ff : base_ml;
         total_load_in = sat_add(base_tl, TW'(b_dur_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         job_valid_ff  <= '0;
         mach_valid_ff <= '0;
         makespan_ff   <= '0;
         completion_ff <= '0;
         max_load_ff   <= '0;
         total_load_ff <= '0;
      end else begin
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         job_valid_ff  <= job_valid_in;
         mach_valid_ff <= mach_valid_in;
         makespan_ff   <= makespan_in;
         completion_ff <= completion_in;
         max_load_ff   <= max_load_in;
         total_load_ff <= total_load_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_free) begin
         a_job_ff   <= job_map[req_job_id];
         a_mach_ff  <= mach_map[req_machine_id];
         a_dur_ff   <= req_duration;
         a_fin_ff   <= req_job_finished;
         a_fresh_ff <= req_new_schedule;
      end
      if (a_move) begin
         fj_idx_ff  <= a_job_ff;
         fj_data_ff <= a_end;
         fm_idx_ff  <= a_mach_ff;
         fm_data_ff <= {a_load, a_end};
      end
      if (b_free) begin
         b_start_ff <= a_start;
         b_end_ff   <= a_end;
         b_load_ff  <= a_load;
         b_dur_ff   <= a_dur_ff;
         b_fin_ff   <= a_fin_ff;
         b_fresh_ff <= a_fresh_ff;
      end
      if (out_free) begin
         o_start_ff <= b_start_ff;
         o_end_ff   <= b_end_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_start_time       = OUT_W'(o_start_ff);
   assign rsp_end_time         = OUT_W'(o_end_ff);
   assign rsp_makespan         = OUT_W'(makespan_ff);
   assign rsp_total_completion = OUT_W'(completion_ff);
   assign rsp_max_workload     = OUT_W'(max_load_ff);
   assign rsp_total_workload   = OUT_W'(total_load_ff);
endmodule
`default_nettype wire

// ===== rtl/core/fjsb_checker.sv =====
// Port-level checks for the schedule builder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fjsb_checker #(
   parameter int unsigned MAX_JOBS     = 64,
   parameter int unsigned MAX_MACHINES = 32,
   parameter int unsigned TIME_BITS    = 32
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [fjsb_pkg::OUT_W-1:0]      rsp_start_time,
   input logic [fjsb_pkg::OUT_W-1:0]      rsp_end_time,
   input logic [fjsb_pkg::OUT_W-1:0]      rsp_makespan,
   input logic [fjsb_pkg::OUT_W-1:0]      rsp_max_workload,
   input logic [fjsb_pkg::OUT_W-1:0]      rsp_total_workload
);
   import fjsb_pkg::*;

   // orderings only hold while times fit the 32-bit output words
   localparam bit FITS = (TIME_BITS <= OUT_W) && (MAX_JOBS > 0) && (MAX_MACHINES > 0);

   // a held word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_end_time)
                                     && $stable(rsp_makespan)))
      else $error("result word changed while stalled");

   // input only backs up once the whole pipeline is full behind a stalled result
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low without output stall");

   a_end_after_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && FITS) |-> (rsp_end_time >= rsp_start_time))
      else $error("end time before start time");

   a_makespan_covers_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && FITS) |-> (rsp_makespan >= rsp_end_time))
      else $error("makespan below end time");

   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && FITS) |-> (rsp_max_workload <= rsp_total_workload))
      else $error("machine workload above total workload");
endmodule

bind flexible_job_shop_schedule_builder_unit fjsb_checker #(
   .MAX_JOBS     (MAX_JOBS),
   .MAX_MACHINES (MAX_MACHINES),
   .TIME_BITS    (TIME_BITS)
) u_fjsb_checker (.*);
`default_nettype wire
